// ----- hw/rtl/ssort_pkg.sv -----
// Shared constants for the selection sorter.
package ssort_pkg;

   // Default number of words one set may hold.
   localparam int unsigned SSORT_MAX_ELEMENTS = 64;

   // Default width of one sorted value.
   localparam int unsigned SSORT_DATA_WIDTH = 32;

endpackage : ssort_pkg

// ----- hw/rtl/ssort_if.sv -----
// Valid/ready channel interfaces for the selection sorter input and result words.
interface ssort_req_if #(
   parameter int unsigned DATA_WIDTH = 32
);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] value;
   logic                         final_item;

   modport source (output valid, output value, output final_item, input ready);
   modport sink   (input valid, input value, input final_item, output ready);
endinterface : ssort_req_if

interface ssort_rsp_if #(
   parameter int unsigned DATA_WIDTH = 32
);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] sorted_value;
   logic                         final_result;
   logic                         overflow;

   modport source (output valid, output sorted_value, output final_result,
                   output overflow, input ready);
   modport sink   (input valid, input sorted_value, input final_result,
                   input overflow, output ready);
endinterface : ssort_rsp_if

// ----- hw/rtl/selection_sorter.sv -----
// Top level of the selection sorter: loads a set of words, sorts it and streams it out.
//
// The block collects a set of signed words, one per accepted input word, into a
// memory of MAX_ELEMENTS entries; the word with final_item set closes the set.
// Words that arrive while the memory is full are dropped, and every result of
// that set then carries overflow. After the closing word the block runs one
// selection pass per stored element: pass i reads entries i through n-1 from
// the memory, one entry per cycle through its single read port, keeps the
// smallest value (the earliest on ties), presents it as the next result and
// writes the displaced entry back into the slot the minimum came from. A pass
// waits to emit while the output register holds an untaken result. Loading
// accepts one word per cycle. No new input word is accepted until the last
// result of the set has been placed in the output register; that register
// holds a result until it is taken, so loading of the next set can overlap
// with the wait for the final result. The memory needs no clearing: only
// entries written in the current set are read.
module selection_sorter
   import ssort_pkg::*;
#(
   parameter int unsigned MAX_ELEMENTS = SSORT_MAX_ELEMENTS,
   parameter int unsigned DATA_WIDTH   = SSORT_DATA_WIDTH
) (
   input  logic  clock,
   input  logic  reset,
   ssort_req_if.sink   req_chan,
   ssort_rsp_if.source rsp_chan
);

   // Index width addresses the memory; count width also holds MAX_ELEMENTS itself.
   localparam int unsigned IDX_W = $clog2(MAX_ELEMENTS);
   localparam int unsigned CNT_W = IDX_W + 1;
   localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_ELEMENTS);

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_START,
      ST_SCAN,
      ST_EMIT
   } state_type;

   state_type                    state_ff, state_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic                         dropped_ff, dropped_in;
   logic [CNT_W-1:0]             n_ff, n_in;
   logic [IDX_W-1:0]             pass_ff, pass_in;
   logic [IDX_W-1:0]             rd_idx_ff, rd_idx_in;
   logic                         first_ff, first_in;
   logic signed [DATA_WIDTH-1:0] best_val_ff, best_val_in;
   logic [IDX_W-1:0]             best_idx_ff, best_idx_in;
   logic signed [DATA_WIDTH-1:0] head_val_ff, head_val_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   logic                         rsp_final_ff, rsp_final_in;
   logic                         rsp_ovf_ff, rsp_ovf_in;

   logic                         ram_wr_en;
   logic [IDX_W-1:0]             ram_wr_addr;
   logic [DATA_WIDTH-1:0]        ram_wr_data;
   logic [IDX_W-1:0]             ram_rd_addr;
   logic [DATA_WIDTH-1:0]        ram_rd_data;

   logic                         req_fire;
   logic                         store_full;
   logic                         scan_more;
   logic                         last_pass;
   logic                         out_free;

   ssort_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (MAX_ELEMENTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_chan.ready        = (state_ff == ST_LOAD);
   assign req_fire              = req_chan.valid && (state_ff == ST_LOAD);
   assign store_full            = (count_ff == MAX_COUNT);
   assign scan_more             = ((CNT_W'(rd_idx_ff) + CNT_W'(1)) < n_ff);
   assign last_pass             = ((CNT_W'(pass_ff) + CNT_W'(1)) == n_ff);
   assign out_free              = !rsp_valid_ff || rsp_chan.ready;

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.sorted_value = rsp_value_ff;
   assign rsp_chan.final_result = rsp_final_ff;
   assign rsp_chan.overflow     = rsp_ovf_ff;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      dropped_in   = dropped_ff;
      n_in         = n_ff;
      pass_in      = pass_ff;
      rd_idx_in    = rd_idx_ff;
      first_in     = first_ff;
      best_val_in  = best_val_ff;
      best_idx_in  = best_idx_ff;
      head_val_in  = head_val_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_value_in = rsp_value_ff;
      rsp_final_in = rsp_final_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = count_ff[IDX_W-1:0];
      ram_wr_data  = req_chan.value;
      ram_rd_addr  = pass_ff;

      case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               // Store while there is room; otherwise remember the loss.
               if (!store_full) begin
                  ram_wr_en = 1'b1;
                  count_in  = count_ff + CNT_W'(1);
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_chan.final_item) begin
                  n_in     = store_full ? count_ff : count_ff + CNT_W'(1);
                  pass_in  = '0;
                  state_in = ST_START;
               end
            end
         end

         ST_START: begin
            // Read the head entry of the unsorted rest.
            ram_rd_addr = pass_ff;
            rd_idx_in   = pass_ff;
            first_in    = 1'b1;
            state_in    = ST_SCAN;
         end

         ST_SCAN: begin
            // Read data belongs to rd_idx_ff; the head entry seeds the minimum.
            first_in = 1'b0;
            if (first_ff) begin
               best_val_in = ram_rd_data;
               best_idx_in = rd_idx_ff;
               head_val_in = ram_rd_data;
            end else if ($signed(ram_rd_data) < best_val_ff) begin
               best_val_in = ram_rd_data;
               best_idx_in = rd_idx_ff;
            end
            if (scan_more) begin
               ram_rd_addr = rd_idx_ff + IDX_W'(1);
               rd_idx_in   = rd_idx_ff + IDX_W'(1);
            end else begin
               state_in = ST_EMIT;
            end
         end

         ST_EMIT: begin
            if (out_free) begin
               // The minimum is final for this slot and goes straight out; the
               // displaced head moves into the slot the minimum came from.
               rsp_valid_in = 1'b1;
               rsp_value_in = best_val_ff;
               rsp_final_in = last_pass;
               rsp_ovf_in   = dropped_ff;
               ram_wr_en    = 1'b1;
               ram_wr_addr  = best_idx_ff;
               ram_wr_data  = head_val_ff;
               if (last_pass) begin
                  count_in   = '0;
                  dropped_in = 1'b0;
                  state_in   = ST_LOAD;
               end else begin
                  pass_in  = pass_ff + IDX_W'(1);
                  state_in = ST_START;
               end
            end
         end

         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         first_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
         first_ff     <= first_in;
      end
      n_ff         <= n_in;
      pass_ff      <= pass_in;
      rd_idx_ff    <= rd_idx_in;
      best_val_ff  <= best_val_in;
      best_idx_ff  <= best_idx_in;
      head_val_ff  <= head_val_in;
      rsp_value_ff <= rsp_value_in;
      rsp_final_ff <= rsp_final_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   // The fill count never passes the memory depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_COUNT)
      else $error("element count exceeds memory depth");

   // While sorting, the set is non-empty and the pass lies inside it.
   a_pass_in_set: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_LOAD) |-> (n_ff != '0) && (CNT_W'(pass_ff) < n_ff))
      else $error("sort pass outside the stored set");

   // A new result word is only loaded from the emit step.
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff) && !$past(reset))
         |-> $past(state_ff) == ST_EMIT)
      else $error("result word appeared outside the emit step");

   // Emitting the final word of a set clears the set state for the next one.
   a_set_cleared: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && out_free && last_pass)
         |=> (state_ff == ST_LOAD) && (count_ff == '0) && !dropped_ff && rsp_final_ff)
      else $error("set state not cleared after its final word");

endmodule : selection_sorter

// ----- hw/rtl/ssort_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
module ssort_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule : ssort_ram

// ----- sim/ssort_checker.sv -----
// Predicts the sorted result words from the input channel and checks the result channel.
`timescale 1ns / 100ps

module ssort_checker
   import ssort_pkg::*;
#(
   parameter int unsigned MAX_ELEMENTS = SSORT_MAX_ELEMENTS,
   parameter int unsigned DATA_WIDTH   = SSORT_DATA_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   ssort_req_if        req_mon,
   ssort_rsp_if        rsp_mon,
   output int unsigned fail_count,
   output int unsigned pending_count
);

   typedef struct packed {
      logic [DATA_WIDTH-1:0] sorted_value;
      logic                  final_result;
      logic                  overflow;
   } sorted_word_type;

   sorted_word_type              awaited_words [$];
   logic signed [DATA_WIDTH-1:0] set_store [MAX_ELEMENTS];
   int unsigned                  set_fill;
   logic                         set_overflowed;
   int unsigned                  mismatches = 0;

   always @(posedge clock) begin : watch
      logic signed [DATA_WIDTH-1:0] ordered [MAX_ELEMENTS];
      logic signed [DATA_WIDTH-1:0] swap_word;
      int unsigned                  best;
      sorted_word_type              seen;
      sorted_word_type              wanted;

      if (reset) begin
         set_fill       = 0;
         set_overflowed = 1'b0;
      end else begin
         // Load side: store the word, or note that the set lost one.
         if (req_mon.valid && req_mon.ready) begin
            if (set_fill < MAX_ELEMENTS) begin
               set_store[set_fill] = req_mon.value;
               set_fill++;
            end else begin
               set_overflowed = 1'b1;
            end
            if (req_mon.final_item) begin
               ordered = set_store;
               // Selection passes, strict signed less-than, earliest minimum wins.
               for (int unsigned i = 0; i + 1 < set_fill; i++) begin
                  best = i;
                  for (int unsigned j = i + 1; j < set_fill; j++) begin
                     if (ordered[j] < ordered[best]) best = j;
                  end
                  if (best != i) begin
                     swap_word     = ordered[i];
                     ordered[i]    = ordered[best];
                     ordered[best] = swap_word;
                  end
               end
               for (int unsigned k = 0; k < set_fill; k++) begin
                  awaited_words.push_back('{ordered[k], k + 1 == set_fill, set_overflowed});
               end
               set_fill       = 0;
               set_overflowed = 1'b0;
            end
         end

         // Result side: every word taken must match the oldest prediction.
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen = '{rsp_mon.sorted_value, rsp_mon.final_result, rsp_mon.overflow};
            if (awaited_words.size() == 0) begin
               if (mismatches < 10) begin
                  $display("[%0t] unexpected result word: value=%0d final=%0b overflow=%0b",
                           $realtime, $signed(seen.sorted_value), seen.final_result,
                           seen.overflow);
               end
               mismatches++;
            end else begin
               wanted = awaited_words.pop_front();
               if (seen !== wanted) begin
                  if (mismatches < 10) begin
                     $display("[%0t] result mismatch: expected value=%0d final=%0b overflow=%0b",
                              $realtime, $signed(wanted.sorted_value), wanted.final_result,
                              wanted.overflow);
                     $display("[%0t]                  actual   value=%0d final=%0b overflow=%0b",
                              $realtime, $signed(seen.sorted_value), seen.final_result,
                              seen.overflow);
                  end
                  mismatches++;
               end
            end
         end
      end

      fail_count    <= mismatches;
      pending_count <= awaited_words.size();
   end

endmodule : ssort_checker

// ----- sim/tb_selection_sorter.sv -----
// Testbench top for the selection sorter: drives sets of words and gives the verdict.
`timescale 1ns / 100ps

module tb_selection_sorter;
   import ssort_pkg::*;

   // Random stimulus stops once about this many words have been offered.
   localparam int unsigned RANDOM_WORDS = 210;
   // Length of the one long receiver hold-off, in clock cycles.
   localparam int unsigned HOLD_LENGTH  = 400;
   // Quiet time after the last expected word.
   localparam int unsigned SETTLE_CYCLES = 3000;

   // Idling patterns; the random part rotates through them set by set.
   typedef enum int unsigned {
      PHASE_STEADY,
      PHASE_SEND_IDLE,
      PHASE_RECV_STALL,
      PHASE_BOTH_IDLE
   } idle_phase_type;

   logic           clock = 1'b0;
   logic           reset = 1'b1;
   idle_phase_type idle_phase = PHASE_STEADY;
   logic           hold_request = 1'b0;
   int unsigned    hold_cycles = 0;
   logic           hold_done = 1'b0;
   int unsigned    check_failures;
   int unsigned    results_pending;

   ssort_req_if #(.DATA_WIDTH(SSORT_DATA_WIDTH)) req_chan ();
   ssort_rsp_if #(.DATA_WIDTH(SSORT_DATA_WIDTH)) rsp_chan ();

   selection_sorter #(
      .MAX_ELEMENTS (SSORT_MAX_ELEMENTS),
      .DATA_WIDTH   (SSORT_DATA_WIDTH)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // The checker sees both channels exactly as the block does and reports
   // its failure count and the number of result words still outstanding.
   ssort_checker #(
      .MAX_ELEMENTS (SSORT_MAX_ELEMENTS),
      .DATA_WIDTH   (SSORT_DATA_WIDTH)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .fail_count    (check_failures),
      .pending_count (results_pending)
   );

   // 4 ns clock period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Receiver. Normally ready follows the stall rate of the current phase.
   // Once, on request from the stimulus, ready is held low for a long counted
   // stretch so that the output register fills, the block stops taking input
   // words, and the sender is left waiting on a full pipeline.
   always @(posedge clock) begin
      if (hold_cycles != 0) begin
         rsp_chan.ready <= 1'b0;
         hold_cycles    <= hold_cycles - 1;
      end else if (hold_request && !hold_done) begin
         rsp_chan.ready <= 1'b0;
         hold_cycles    <= HOLD_LENGTH;
         hold_done      <= 1'b1;
      end else begin
         rsp_chan.ready <= ($urandom_range(0, 99) >=
                            ((idle_phase == PHASE_RECV_STALL) ? 53 :
                             (idle_phase == PHASE_BOTH_IDLE)  ? 34 : 0));
      end
   end

   // Offer one input word, with random idle cycles ahead of it, and return
   // just after the edge at which the block took it. Called right after a
   // rising edge, so each call makes at most one assignment to valid per step.
   task automatic send_word(input logic signed [SSORT_DATA_WIDTH-1:0] word,
                            input logic last_word);
      while ($urandom_range(0, 99) < ((idle_phase == PHASE_SEND_IDLE) ? 53 :
                                      (idle_phase == PHASE_BOTH_IDLE) ? 34 : 0)) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.value      <= word;
      req_chan.final_item <= last_word;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // Random element values: mostly full-range, with a share of the extremes
   // and of a narrow band around zero so that equal values are common.
   function automatic logic signed [SSORT_DATA_WIDTH-1:0] pick_value();
      case ($urandom_range(0, 9))
         7:       return {1'b0, {(SSORT_DATA_WIDTH-1){1'b1}}};
         8:       return {1'b1, {(SSORT_DATA_WIDTH-1){1'b0}}};
         9:       return ($urandom_range(0, 1) != 0) ? '0 : '1;
         5, 6:    return SSORT_DATA_WIDTH'($signed($urandom_range(0, 8)) - 4);
         default: return SSORT_DATA_WIDTH'({$urandom, $urandom});
      endcase
   endfunction

   initial begin : stimulus
      int unsigned random_words;
      int unsigned set_index;
      int unsigned set_size;

      // Every input of the block starts at a known value.
      req_chan.valid      = 1'b0;
      req_chan.value      = '0;
      req_chan.final_item = 1'b0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed sets. One-word sets at both extremes of the value range.
      send_word(32'sh7fffffff, 1'b1);
      send_word(32'sh80000000, 1'b1);
      // Extremes, zero, minus one and a repeated value in one set.
      send_word(32'sd0, 1'b0);
      send_word(-32'sd1, 1'b0);
      send_word(32'sh7fffffff, 1'b0);
      send_word(32'sh80000000, 1'b0);
      send_word(32'sd1, 1'b0);
      send_word(-32'sd1, 1'b0);
      send_word(32'sd5, 1'b1);
      // Already in order, so no pass needs a swap.
      send_word(32'sd1, 1'b0);
      send_word(32'sd2, 1'b0);
      send_word(32'sd3, 1'b1);
      // Reversed order.
      send_word(32'sd3, 1'b0);
      send_word(32'sd2, 1'b0);
      send_word(32'sd1, 1'b1);
      // Two equal values.
      send_word(32'sd5, 1'b0);
      send_word(32'sd5, 1'b1);

      // Random sets. Set 1 overruns the store by two words, so a non-final
      // word and the closing word are both dropped; set 3 fills the store
      // exactly. The rest are mostly small to keep the sort time short.
      random_words = 0;
      set_index    = 0;
      while (random_words < RANDOM_WORDS) begin
         idle_phase <= idle_phase_type'(set_index % 4);
         if (set_index == 1)      set_size = SSORT_MAX_ELEMENTS + 2;
         else if (set_index == 3) set_size = SSORT_MAX_ELEMENTS;
         else if (set_index == 4) set_size = 20;
         else if ($urandom_range(0, 9) == 0) set_size = $urandom_range(13, 30);
         else                     set_size = $urandom_range(1, 12);
         // Set 4 has just closed when set 5 starts: hold the receiver off
         // while its results wait and set 5 queues up behind them.
         if (set_index == 5) hold_request <= 1'b1;
         for (int unsigned k = 0; k < set_size; k++) begin
            send_word(pick_value(), k + 1 == set_size);
            random_words++;
         end
         set_index++;
      end
      req_chan.valid <= 1'b0;

      // Let the checker register the last set, wait for its results, then
      // watch a while longer for any word that should not come.
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (check_failures == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // A normal run takes well under a tenth of this.
   initial begin
      #3_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule : tb_selection_sorter
